### rtl/wfc_pkg.sv
// shared types and constants for the word frequency counter
package wfc_pkg;
  localparam int CharW = 8;
  localparam int TABLE_ENTRIES = 128;
  localparam int COUNT_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP_REQ,
    ST_CMP_WAIT,
    ST_CMP_CHECK,
    ST_COPY,
    ST_RESULT
  } wfc_state_t;

  typedef struct packed {
    logic load_byte;
    logic start_search;
    logic next_entry;
    logic byte_step;
    logic append;
    logic bump;
    logic copy_step;
    logic emit_result;
    logic report_full;
  } wfc_cmd_t;

  typedef struct packed {
    logic closes;
    logic word_empty;
    logic entry_mismatch;
    logic bytes_done;
    logic table_end;
    logic table_full;
    logic copy_done;
    logic out_busy;
  } wfc_status_t;

  function automatic logic is_delim(input logic [CharW-1:0] b);
    case (b)
      8'h20, 8'h2e, 8'h2c, 8'h3b, 8'h3a, 8'h21, 8'h3f, 8'h27, 8'h22: is_delim = 1'b1;
      default: is_delim = 1'b0;
    endcase
  endfunction
endpackage

### rtl/wfc_in_if.sv
// input channel interface
interface wfc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_byte;
  logic       last;
  modport source (output valid, func, char_byte, last, input ready);
  modport sink (input valid, func, char_byte, last, output ready);
endinterface

### rtl/wfc_out_if.sv
// result channel interface
interface wfc_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  entry_index;
  logic [15:0] word_count;
  logic        new_entry;
  logic        table_full;
  logic        word_truncated;
  modport source (output valid, entry_index, word_count, new_entry, table_full,
                  word_truncated, input ready);
  modport sink (input valid, entry_index, word_count, new_entry, table_full,
                word_truncated, output ready);
endinterface

### rtl/wfc_ram.sv
// generic single-port-write ram with registered read
module wfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/wfc_ctrl.sv
// controller state machine for word closing, search, count update, append and result hand-off
module wfc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wfc_pkg::wfc_status_t status,
  output wfc_pkg::wfc_cmd_t   cmd
);
  import wfc_pkg::*;

  wfc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          if (status.closes && !status.word_empty) begin
            cmd.start_search = 1'b1;
            state_next = ST_CMP_REQ;
          end
        end
      end
      ST_CMP_REQ: begin
        if (status.table_end) begin
          if (status.table_full) begin
            cmd.report_full = 1'b1;
            state_next = ST_RESULT;
          end else begin
            state_next = ST_COPY;
          end
        end else begin
          state_next = ST_CMP_WAIT;
        end
      end
      ST_CMP_WAIT: begin
        cmd.byte_step = 1'b1;
        state_next = ST_CMP_CHECK;
      end
      ST_CMP_CHECK: begin
        if (status.entry_mismatch) begin
          cmd.next_entry = 1'b1;
          state_next = ST_CMP_REQ;
        end else if (status.bytes_done) begin
          cmd.bump = 1'b1;
          state_next = ST_RESULT;
        end else begin
          cmd.byte_step = 1'b1;
        end
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (status.copy_done) begin
          cmd.append = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!status.out_busy) begin
          cmd.emit_result = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

### rtl/wfc_datapath.sv
// word buffer, table memories, compare and count update
module wfc_datapath #(
  parameter int MAX_WORD_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fold_case,
  input  logic                 in_func,
  input  logic [7:0]           in_char_byte,
  input  logic                 in_last,
  input  wfc_pkg::wfc_cmd_t    cmd,
  output wfc_pkg::wfc_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [6:0]           out_entry_index,
  output logic [15:0]          out_word_count,
  output logic                 out_new_entry,
  output logic                 out_table_full,
  output logic                 out_word_truncated
);
  import wfc_pkg::*;

  localparam int EW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int BW = $clog2(MAX_WORD_LEN);
  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int SW = EW + BW;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [CW-1:0] entries_used;
  logic [LW-1:0] cur_len;
  logic          cur_trunc;
  logic [EW-1:0] entry;
  logic [CW-1:0] entry_cnt;
  logic [LW-1:0] pos;
  logic [BW-1:0] rd_pos;

  logic [EW-1:0]         res_index;
  logic [COUNT_BITS-1:0] res_count;
  logic                  res_new;
  logic                  res_full;
  logic                  res_trunc;

  logic [7:0] b;
  logic       delim;

  always_comb begin
    b = in_char_byte;
    if (fold_case && b >= 8'h41 && b <= 8'h5a) begin
      b = b + 8'h20;
    end
  end
  assign delim = is_delim(b);

  // current word buffer
  logic          cw_we;
  logic [BW-1:0] cw_raddr;
  logic [7:0]    cw_rdata;
  assign cw_we = cmd.load_byte && !in_func && !delim && (cur_len < LW'(MAX_WORD_LEN));
  assign cw_raddr = (cmd.copy_step || cmd.byte_step) ? rd_pos : '0;

  wfc_ram #(.WIDTH(8), .DEPTH(MAX_WORD_LEN)) u_cur (
    .clk(clk), .we(cw_we), .waddr(cur_len[BW-1:0]), .wdata(b),
    .raddr(cw_raddr), .rdata(cw_rdata)
  );

  // word store
  logic          ws_we;
  logic [SW-1:0] ws_waddr;
  logic [7:0]    ws_rdata;
  logic [BW-1:0] copy_wpos;
  logic          copy_pend;
  assign ws_we = copy_pend;
  assign ws_waddr = {entries_used[EW-1:0], copy_wpos};

  wfc_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * MAX_WORD_LEN)) u_store (
    .clk(clk), .we(ws_we), .waddr(ws_waddr), .wdata(cw_rdata),
    .raddr({entry, rd_pos}), .rdata(ws_rdata)
  );

  // lengths and counts
  logic [LW-1:0]         len_rdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  cnt_we;
  logic [EW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  wfc_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_len (
    .clk(clk), .we(cmd.append), .waddr(entries_used[EW-1:0]), .wdata(cur_len),
    .raddr(entry), .rdata(len_rdata)
  );

  wfc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_ENTRIES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(entry), .rdata(cnt_rdata)
  );

  logic [COUNT_BITS-1:0] bumped;
  assign bumped = (cnt_rdata == CountMax) ? cnt_rdata : cnt_rdata + 1'b1;
  assign cnt_we = cmd.append || cmd.bump;
  assign cnt_waddr = cmd.append ? entries_used[EW-1:0] : entry;
  assign cnt_wdata = cmd.append ? COUNT_BITS'(1) : bumped;

  // compare tracking: pos counts compared bytes, rd_pos is next read address
  logic cmp_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
      cur_len <= '0;
      cur_trunc <= 1'b0;
      copy_pend <= 1'b0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      copy_pend <= cmd.copy_step && !status.copy_done;
      if (copy_pend) begin
        copy_wpos <= copy_wpos + 1'b1;
      end
      if (cmd.load_byte) begin
        if (in_func) begin
          entries_used <= '0;
          cur_len <= '0;
          cur_trunc <= 1'b0;
        end else if (!delim) begin
          if (cur_len < LW'(MAX_WORD_LEN)) begin
            cur_len <= cur_len + 1'b1;
          end else begin
            cur_trunc <= 1'b1;
          end
        end
      end
      if (cmd.start_search) begin
        entry <= '0;
        entry_cnt <= '0;
        rd_pos <= '0;
        pos <= '0;
        copy_wpos <= '0;
        res_trunc <= cur_trunc || (!delim && cur_len == LW'(MAX_WORD_LEN));
      end
      if (cmd.next_entry) begin
        entry <= entry + 1'b1;
        entry_cnt <= entry_cnt + 1'b1;
        rd_pos <= '0;
        pos <= '0;
      end
      cmp_valid <= cmd.byte_step;
      if (cmd.byte_step) begin
        rd_pos <= rd_pos + 1'b1;
        if (cmp_valid) begin
          pos <= pos + 1'b1;
        end
      end
      if (cmd.copy_step) begin
        rd_pos <= rd_pos + 1'b1;
        pos <= pos + 1'b1;
      end
      if (cmd.append) begin
        entries_used <= entries_used + 1'b1;
      end
      if (cmd.bump) begin
        res_count <= bumped;
        res_index <= entry;
        res_new <= 1'b0;
        res_full <= 1'b0;
      end
      if (cmd.append) begin
        res_count <= COUNT_BITS'(1);
        res_index <= entries_used[EW-1:0];
        res_new <= 1'b1;
        res_full <= 1'b0;
      end
      if (cmd.report_full) begin
        res_count <= '0;
        res_index <= '0;
        res_new <= 1'b0;
        res_full <= 1'b1;
      end
      if (cmd.emit_result) begin
        out_valid <= 1'b1;
        out_entry_index <= 7'(res_index);
        out_word_count <= 16'(res_count);
        out_new_entry <= res_new;
        out_table_full <= res_full;
        out_word_truncated <= res_trunc;
        cur_len <= '0;
        cur_trunc <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the byte that arrives with last is already in cur_len when the search starts
  always_comb begin
    status = '0;
    status.closes = in_func ? 1'b0 : (delim || in_last);
    status.word_empty = delim ? (cur_len == '0) : 1'b0;
    status.table_end = (entry_cnt == entries_used);
    status.table_full = (entries_used == CW'(TABLE_ENTRIES));
    // in CMP_CHECK, every check compares the lengths as well as the bytes at pos
    status.entry_mismatch = (len_rdata != cur_len) ||
                            (pos < cur_len && ws_rdata != cw_rdata);
    status.bytes_done = (LW'(pos) + 1'b1 >= cur_len);
    status.copy_done = (pos >= cur_len);
    status.out_busy = out_valid && !out_ready;
  end
endmodule

### rtl/word_frequency_counter_top.sv
// top level of the word frequency counter
// Takes one text byte per transaction and reports one result per completed word.
// A plain byte is taken in IDLE; a word close searches the table entry by entry,
// comparing one stored byte per cycle through the word store memory; an entry of
// another length is rejected at its first check, and an entry of matching length
// is compared byte by byte. A new word then sees the end of the table and is
// appended by a byte copy into the word store, and the result is then loaded.
// Results pass through an output register so the next byte is taken
// while a result waits.
module word_frequency_counter_top #(
  parameter int MAX_WORD_LEN = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  wfc_in_if.sink    in_ch,
  wfc_out_if.source out_ch
);
  import wfc_pkg::*;

  logic        fold_case;
  wfc_cmd_t    cmd;
  wfc_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_case <= 1'b1;
    end else if (cfg_we) begin
      fold_case <= cfg_wdata;
    end
  end

  wfc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .status(status), .cmd(cmd)
  );

  wfc_datapath #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_dp (
    .clk(clk), .rst(rst), .fold_case(fold_case),
    .in_func(in_ch.func), .in_char_byte(in_ch.char_byte), .in_last(in_ch.last),
    .cmd(cmd), .status(status),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_entry_index(out_ch.entry_index), .out_word_count(out_ch.word_count),
    .out_new_entry(out_ch.new_entry), .out_table_full(out_ch.table_full),
    .out_word_truncated(out_ch.word_truncated)
  );

`ifndef SYNTH
  a_new_full: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.new_entry && out_ch.table_full))
    else $error("new entry and table full together");
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.table_full |-> out_ch.word_count == '0)
    else $error("table full with nonzero count");
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.table_full |-> out_ch.word_count != '0)
    else $error("zero count on stored word");
`endif
endmodule

### dv/word_frequency_counter_top_tb.sv
// testbench for the word frequency counter: table predictor, byte stimulus, result scoreboard
module word_frequency_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = 128;
  localparam int WordMax = 64;
  localparam int CountMax = 65535;

  typedef struct packed {
    logic [6:0]  entry_index;
    logic [15:0] word_count;
    logic        new_entry;
    logic        table_full;
    logic        word_truncated;
  } word_result_t;

  class word_table_sb;
    bit [7:0]     slot_bytes[NumSlots][WordMax];
    int           slot_len[NumSlots];
    int           slot_count[NumSlots];
    int           slots_used;
    bit [7:0]     word_buf[WordMax];
    int           word_len;
    bit           word_cut;
    bit           fold_case;
    word_result_t expected_q[$];
    int           errors;
    int           results_seen;

    function void clear_all();
      slots_used = 0;
      word_len = 0;
      word_cut = 0;
    endfunction

    function bit is_delim(bit [7:0] b);
      return b inside {8'h20, 8'h2e, 8'h2c, 8'h3b, 8'h3a, 8'h21, 8'h3f, 8'h27, 8'h22};
    endfunction

    function void close_word();
      word_result_t r;
      int i;
      bit hit;
      if (word_len == 0) return;
      r = '0;
      r.word_truncated = word_cut;
      hit = 0;
      for (i = 0; i < slots_used; i++) begin
        if (slot_len[i] == word_len) begin
          hit = 1;
          for (int k = 0; k < word_len; k++)
            if (slot_bytes[i][k] != word_buf[k]) hit = 0;
        end
        if (hit) break;
      end
      if (hit) begin
        if (slot_count[i] < CountMax) slot_count[i]++;
        r.entry_index = i[6:0];
        r.word_count = slot_count[i][15:0];
      end else if (slots_used < NumSlots) begin
        for (int k = 0; k < word_len; k++) slot_bytes[slots_used][k] = word_buf[k];
        slot_len[slots_used] = word_len;
        slot_count[slots_used] = 1;
        r.entry_index = slots_used[6:0];
        r.word_count = 16'd1;
        r.new_entry = 1'b1;
        slots_used++;
      end else begin
        r.table_full = 1'b1;
      end
      expected_q.push_back(r);
      word_len = 0;
      word_cut = 0;
    endfunction

    function void note_input(bit func, bit [7:0] b, bit is_last);
      if (func) begin
        clear_all();
        return;
      end
      if (fold_case && b >= 8'h41 && b <= 8'h5a) b = b + 8'h20;
      if (is_delim(b)) begin
        close_word();
        return;
      end
      if (word_len < WordMax) begin
        word_buf[word_len] = b;
        word_len++;
      end else begin
        word_cut = 1;
      end
      if (is_last) close_word();
    endfunction

    function void check_result(word_result_t got);
      word_result_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.entry_index != exp.entry_index)
        $display("%0t: entry_index expected %0d actual %0d", $time, exp.entry_index,
                 got.entry_index);
      if (got.word_count != exp.word_count)
        $display("%0t: word_count expected %0d actual %0d", $time, exp.word_count,
                 got.word_count);
      if (got.new_entry != exp.new_entry)
        $display("%0t: new_entry expected %0b actual %0b", $time, exp.new_entry,
                 got.new_entry);
      if (got.table_full != exp.table_full)
        $display("%0t: table_full expected %0b actual %0b", $time, exp.table_full,
                 got.table_full);
      if (got.word_truncated != exp.word_truncated)
        $display("%0t: word_truncated expected %0b actual %0b", $time,
                 exp.word_truncated, got.word_truncated);
      if (got != exp) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  string vocab[$];
  word_table_sb sb;

  wfc_in_if  in_ch ();
  wfc_out_if out_ch ();

  word_frequency_counter_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.entry_index, out_ch.word_count, out_ch.new_entry,
                       out_ch.table_full, out_ch.word_truncated});
  end

  task automatic send_byte(bit func, bit [7:0] b, bit is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.char_byte <= b;
    in_ch.last <= is_last;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sb.note_input(func, b, is_last);
    items_sent++;
  endtask

  task automatic send_text(string s, bit last_on_end);
    for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i], last_on_end && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_fold(bit v);
    wait_drained();
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.fold_case = v;
  endtask

  task automatic send_random_word();
    string w;
    bit [7:0] delims[9] = '{8'h20, 8'h2e, 8'h2c, 8'h3b, 8'h3a, 8'h21, 8'h3f, 8'h27, 8'h22};
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) begin
      send_byte(1'b1, 8'($urandom), 1'($urandom));
    end else if (sel < 16) begin
      repeat ($urandom_range(1, 6)) send_byte(1'b0, 8'($urandom), ($urandom_range(9) == 0));
    end else if (sel < 19) begin
      repeat ($urandom_range(60, 70)) send_byte(1'b0, 8'h61 + 8'($urandom_range(2)), 1'b0);
      send_byte(1'b0, delims[$urandom_range(8)], 1'b0);
    end else begin
      w = vocab[$urandom_range(vocab.size() - 1)];
      for (int i = 0; i < w.len(); i++)
        if ($urandom_range(3) == 0 && w[i] >= "a" && w[i] <= "z") w[i] = w[i] - 8'h20;
      if ($urandom_range(4) == 0) begin
        send_text(w, 1'b1);
      end else begin
        send_text(w, 1'b0);
        send_byte(1'b0, delims[$urandom_range(8)], 1'b0);
      end
    end
  endtask

  task automatic run_random(int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) send_random_word();
  endtask

  initial begin
    sb = new();
    sb.fold_case = 1;
    sb.clear_all();
    vocab = '{"the", "a", "cat", "dog", "word", "count", "table", "hi", "x", "zz",
              "logic", "bag", "of", "words", "text", "run", "go", "ab", "ba", "abc"};
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.func = 0;
    in_ch.char_byte = 0;
    in_ch.last = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: case folding, empty words, last flag, odd bytes, long word, clear
    send_text("Hi hi,HI.", 1'b0);
    send_text(" ;", 1'b0);
    send_byte(1'b0, 8'h00, 1'b0);
    send_byte(1'b0, 8'h0a, 1'b0);
    send_byte(1'b0, 8'hff, 1'b1);
    send_byte(1'b0, 8'h22, 1'b1);
    repeat (66) send_byte(1'b0, 8'h71, 1'b0);
    send_byte(1'b0, 8'h27, 1'b0);
    send_byte(1'b1, 8'h41, 1'b1);
    send_text("hi", 1'b1);

    // fill the table past its end
    send_byte(1'b1, 8'h00, 1'b0);
    for (int i = 0; i < NumSlots + 3; i++) begin
      send_byte(1'b0, 8'h80 + 8'(i >> 4), 1'b0);
      send_byte(1'b0, 8'h80 + 8'(i & 15), 1'b1);
    end
    send_text("\x80\x81!", 1'b0);
    send_byte(1'b1, 8'h00, 1'b0);

    write_fold(1'b0);
    send_text("Hi hi HI", 1'b1);

    send_idle_pct = 12;
    recv_idle_pct = 52;
    run_random(60);
    wait_drained();
    run_random(60);
    write_fold(1'b1);
    send_idle_pct = 52;
    recv_idle_pct = 12;
    run_random(110);
    write_fold(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(30);
    write_fold(1'b1);
    run_random(30);

    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d input bytes and %0d word results over both case modes,",
             items_sent, sb.results_seen);
    $display("including a full table, long words, clears and idle on both sides");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("== FAIL ==");
    $finish;
  end
endmodule
